// ===== hdl/sha_pkg.sv =====
// Package for the SHA-256 stream hasher: constants, types and round functions.
// Used by every module under hdl; depends on nothing.
package sha_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned NumRounds = 64;
	localparam int unsigned QueueDepthDefault = 4;

	typedef enum logic [0:0] {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	// Command from the front end to the compression engine.
	typedef struct packed {
		logic        finish;     // emit digest and reinitialise afterwards
		logic [511:0] block;
	} cmd_t;

	localparam logic [255:0] InitHash = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_s0(input logic [31:0] a);
		big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] e);
		big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
	endfunction

	function automatic logic [31:0] sml_s0(input logic [31:0] w);
		sml_s0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
	endfunction

	function automatic logic [31:0] sml_s1(input logic [31:0] w);
		sml_s1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
	endfunction

endpackage

// ===== hdl/sha_if.sv =====
// Valid/ready channel interfaces for the SHA-256 stream hasher.
// Depends on nothing.
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;
	modport source (output valid, op, data_byte, input ready);
	modport sink (input valid, op, data_byte, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last;
	modport source (output valid, digest_word, word_index, last, input ready);
	modport sink (input valid, digest_word, word_index, last, output ready);
endinterface

// ===== hdl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher, top level: front end, command queue and compression engine.
// Depends on sha_pkg, sha_if, sha_front, sha_queue and sha_engine.
//
// Usage. Items arrive on in_ch: op = 0 absorbs data_byte, op = 1 ends the message.
// Each finish request yields eight requests on out_ch carrying the digest words
// in order, word_index 0 to 7, with last set on the eighth. After the final
// word the chaining state, block and length return to their initial values.
// Absorbed bytes are taken one per cycle while in_ch.ready is high; every 64th
// byte hands a full block to the queue, which lets intake go on while the
// engine loads and compresses earlier blocks, until it fills. A finish costs
// one or two compressions (two when more than 55 bytes sit in the block),
// then the eight digest words are sent.
// Reset clears all control state and loads the initial hash values.
// A stalled receiver holds the engine in its output state; the queue then
// fills and in_ch.ready drops until words are taken.
module sha256_stream_hasher import sha_pkg::*; #(
	parameter int unsigned QueueDepth = QueueDepthDefault
) (
	input  logic   clk,
	input  logic   arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch
);

	cmd_t f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_ready;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
	);

	sha_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_cmd(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_cmd(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
	);

	sha_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
		.out_ch(out_ch)
	);

endmodule

// ===== hdl/sha_front.sv =====
// Front end: packs bytes into 512-bit blocks, pads on finish and issues commands.
// Depends on sha_pkg and sha_if.
module sha_front import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sha_in_if.sink     in_ch,
	output cmd_t       cmd,
	output logic       cmd_valid,
	input  logic       cmd_ready
);

	logic [511:0] block_q;
	logic [5:0]   fill_q;
	logic [60:0]  total_q;
	logic         pend_q;      // a padding-only final block still to issue
	logic [63:0]  len_q;

	logic [511:0] with_byte;
	logic [511:0] with_len;
	logic [7:0]   in_byte;

	always_comb begin
		in_byte = (in_ch.op == OP_FINISH) ? 8'h80 : in_ch.data_byte;
		with_byte = block_q;
		with_byte[511 - {fill_q, 3'b000} -: 8] = in_byte;
		with_len = with_byte;
		with_len[63:0] = {total_q, 3'b000};
	end

	assign in_ch.ready = !pend_q && cmd_ready;

	always_comb begin
		cmd_valid = 1'b0;
		cmd = '{finish: 1'b0, block: with_byte};
		if (pend_q) begin
			cmd_valid = 1'b1;
			cmd.finish = 1'b1;
			cmd.block = {448'd0, len_q};
		end else if (in_ch.valid) begin
			if (in_ch.op == OP_FINISH) begin
				cmd_valid = 1'b1;
				// With more than 55 bytes held the length no longer fits.
				if (fill_q <= 6'd55) begin
					cmd.finish = 1'b1;
					cmd.block = with_len;
				end
			end else if (fill_q == 6'd63) begin
				cmd_valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= '0;
			fill_q  <= '0;
			total_q <= '0;
			pend_q  <= 1'b0;
			len_q   <= '0;
		end else if (pend_q) begin
			if (cmd_ready) pend_q <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			if (in_ch.op == OP_FINISH) begin
				block_q <= '0;
				fill_q  <= '0;
				total_q <= '0;
				if (fill_q > 6'd55) begin
					pend_q <= 1'b1;
					len_q  <= {total_q, 3'b000};
				end
			end else begin
				total_q <= total_q + 61'd1;
				fill_q  <= fill_q + 6'd1;
				block_q <= (fill_q == 6'd63) ? '0 : with_byte;
			end
		end
	end

endmodule

// ===== hdl/sha_queue.sv =====
// Small command queue between the front end and the compression engine.
// Depends on sha_pkg.
module sha_queue import sha_pkg::*; #(
	parameter int unsigned Depth = QueueDepthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t wr_cmd,
	input  logic wr_valid,
	output logic wr_ready,
	output cmd_t rd_cmd,
	output logic rd_valid,
	input  logic rd_ready
);

	localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	cmd_t             mem_q [Depth];
	logic [AddrW-1:0] wp_q;
	logic [AddrW-1:0] rp_q;
	logic [AddrW:0]   cnt_q;

	logic do_wr;
	logic do_rd;

	assign wr_ready = (cnt_q != (AddrW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_cmd   = mem_q[rp_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AddrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AddrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AddrW+1)'(do_wr) - (AddrW+1)'(do_rd);
		end
	end

endmodule

// ===== hdl/sha_engine.sv =====
// Compression engine: one round per cycle, message schedule in a 16-word window,
// then eight digest words out on a finish command. Depends on sha_pkg and sha_if.
module sha_engine import sha_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  logic   cmd_valid,
	output logic   cmd_ready,
	sha_out_if.source out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_ROUND = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t        state_q;
	logic [5:0]    rnd_q;
	logic [31:0]   w_q [16];
	logic [31:0]   v_q [8];
	logic [255:0]  chain_q;
	logic          fin_q;
	logic [2:0]    idx_q;

	logic [31:0] t1, t2, w_new;
	logic [31:0] v_nx [8];

	always_comb begin
		t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ RoundK[rnd_q] + w_q[0];
		t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = w_q[0] + sml_s0(w_q[1]) + w_q[9] + sml_s1(w_q[14]);
		for (int i = 1; i < 8; i++) v_nx[i] = v_q[i-1];
		v_nx[0] = t1 + t2;
		v_nx[4] = v_q[3] + t1;
	end

	assign cmd_ready         = (state_q == ST_IDLE);
	assign out_ch.valid       = (state_q == ST_EMIT);
	assign out_ch.digest_word = chain_q[255 - {idx_q, 5'd0} -: 32];
	assign out_ch.word_index  = idx_q;
	assign out_ch.last        = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
			fin_q   <= 1'b0;
			chain_q <= InitHash;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
						fin_q   <= cmd.finish;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(NumRounds - 1)) begin
						for (int i = 0; i < 8; i++) begin
							chain_q[255 - 32*i -: 32] <= chain_q[255 - 32*i -: 32] + v_nx[i];
						end
						idx_q   <= '0;
						state_q <= fin_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_ch.ready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							chain_q <= InitHash;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working variables and schedule window carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			for (int i = 0; i < 16; i++) w_q[i] <= cmd.block[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[255 - 32*i -: 32];
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			for (int i = 0; i < 8; i++) v_q[i] <= v_nx[i];
		end
	end

endmodule

// ===== tb/sha256_stream_hasher_check.sv =====
// Checker for the SHA-256 stream hasher: watches both channels, predicts digests, compares.
// Depends on sha_pkg and sha_if.
module sha256_stream_hasher_check import sha_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	sha_in_if      in_ch,
	sha_out_if     out_ch,
	output int     fail_count,
	output int     words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} digest_req_t;

	logic [31:0] chain [8];
	logic [31:0] msg_block [16];
	int unsigned block_fill;
	logic [60:0] total_bytes;
	digest_req_t expected_words [$];

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic clear_message();
		for (int i = 0; i < 8; i++) chain[i] = InitHash[255 - 32 * i -: 32];
		for (int i = 0; i < 16; i++) msg_block[i] = '0;
		block_fill = 0;
		total_bytes = '0;
	endtask

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++) w[t] = msg_block[t];
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		for (int t = 0; t < 8; t++) v[t] = chain[t];
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int t = 0; t < 8; t++) chain[t] += v[t];
		for (int t = 0; t < 16; t++) msg_block[t] = '0;
		block_fill = 0;
	endtask

	task automatic append_byte(input logic [7:0] b);
		msg_block[block_fill / 4][31 - 8 * (block_fill % 4) -: 8] = b;
		block_fill++;
	endtask

	task automatic predict_request(input op_t op, input logic [7:0] b);
		logic [63:0] bit_len;
		if (op == OP_ABSORB) begin
			append_byte(b);
			if (block_fill >= 64) compress();
			total_bytes++;
		end else begin
			append_byte(8'h80);
			if (block_fill > 56) compress();
			bit_len = {total_bytes, 3'b000};
			msg_block[14] = bit_len[63:32];
			msg_block[15] = bit_len[31:0];
			compress();
			for (int i = 0; i < 8; i++) expected_words.push_back('{chain[i], 3'(i), i == 7});
			clear_message();
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		words_pending = 0;
		clear_message();
	end

	always @(posedge clk) begin
		digest_req_t want;
		if (arst_n && in_ch.valid && in_ch.ready)
			predict_request(op_t'(in_ch.op), in_ch.data_byte);
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected digest word %h", out_ch.digest_word));
			end else begin
				want = expected_words.pop_front();
				if (out_ch.digest_word !== want.digest_word)
					report_mismatch($sformatf("word %0d: got %h, want %h", want.word_index,
						out_ch.digest_word, want.digest_word));
				if (out_ch.word_index !== want.word_index)
					report_mismatch($sformatf("word_index got %0d, want %0d",
						out_ch.word_index, want.word_index));
				if (out_ch.last !== want.last)
					report_mismatch($sformatf("last got %b on word %0d", out_ch.last,
						want.word_index));
			end
		end
		words_pending = expected_words.size();
	end
endmodule

// ===== tb/sha256_stream_hasher_test.sv =====
// Top of the SHA-256 stream hasher testbench: clock, reset, stimulus and verdict.
// Depends on sha_pkg, sha_if, the hasher and sha256_stream_hasher_check.
module sha256_stream_hasher_test;
	import sha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   words_pending;
	int   send_idle_pct;
	int   take_idle_pct;
	longint cycle_count;

	sha_in_if  in_ch();
	sha_out_if out_ch();

	sha256_stream_hasher u_top (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	sha256_stream_hasher_check u_check (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .fail_count(fail_count), .words_pending(words_pending));

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at random, decided at each falling edge.
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 400000) begin
				$display("sha256_stream_hasher verification failed");
				$finish;
			end
		end
	end

	// Present one request and hold it until accepted; optional idle cycles first.
	// Ready is sampled while it is stable, between the edges.
	task automatic send_request(input op_t op, input logic [7:0] b);
		logic acc;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.data_byte <= b;
		do begin
			#1;
			acc = in_ch.ready;
			@(posedge clk);
		end while (!acc);
		@(negedge clk);
	endtask

	task automatic send_message(input int len, input int pattern);
		for (int i = 0; i < len; i++) begin
			case (pattern)
				0: send_request(OP_ABSORB, 8'h00);
				1: send_request(OP_ABSORB, 8'hff);
				2: send_request(OP_ABSORB, 8'(i));
				default: send_request(OP_ABSORB, 8'($urandom));
			endcase
		end
		send_request(OP_FINISH, 8'($urandom));
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.op = OP_ABSORB;
		in_ch.data_byte = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 0;
		take_idle_pct = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty message, then 56 bytes, which forces a padding-only final block.
		send_idle_pct = 31;
		take_idle_pct = 84;
		send_message(0, 0);
		send_message(56, 2);

		// A message beyond one block, so a full block is compressed on absorb.
		send_idle_pct = 84;
		take_idle_pct = 31;
		send_message(66, 3);

		// A few short random messages back to back.
		send_idle_pct = 0;
		take_idle_pct = 0;
		for (int m = 0; m < 3; m++) send_message($urandom_range(2), 3);
		in_ch.valid <= 1'b0;

		while (words_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("sha256_stream_hasher verification clean");
		end else begin
			$display("sha256_stream_hasher verification failed");
		end
		$finish;
	end
endmodule
